[src/gca_pkg.sv]
// shared types, codes and the log table of the graph colouring annealer
package gca_pkg;

  localparam int APB_AW = 5;

  localparam logic [1:0] ACT_SET_ARC   = 2'd0;
  localparam logic [1:0] ACT_SET_COLOR = 2'd1;
  localparam logic [1:0] ACT_START     = 2'd2;
  localparam logic [1:0] ACT_STEP      = 2'd3;

  localparam logic [2:0] REG_NODE_COUNT  = 3'd0;
  localparam logic [2:0] REG_NUM_COLORS  = 3'd1;
  localparam logic [2:0] REG_START_TEMP  = 3'd2;
  localparam logic [2:0] REG_COOLING     = 3'd3;
  localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

  localparam logic [3:0] DRAW_MAX = 4'd9;

  typedef struct packed {
    logic load_in;
    logic arc_read;
    logic arc_write;
    logic color_write;
    logic rem_start;
    logic rem_color;
    logic take_node;
    logic take_color;
    logic scan_start;
    logic use_trial;
    logic mult;
    logic commit_step;
    logic commit_start;
    logic out_load;
  } gca_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       done;
    logic       rem_busy;
    logic       scan_busy;
    logic       out_free;
  } gca_status_t;

  // ln(10/k) in unsigned q2.16
  function automatic logic [17:0] ln_q16(input logic [3:0] k);
    logic [17:0] v;
    case (k)
      4'd1:    v = 18'd150902;
      4'd2:    v = 18'd105476;
      4'd3:    v = 18'd78904;
      4'd4:    v = 18'd60050;
      4'd5:    v = 18'd45426;
      4'd6:    v = 18'd33477;
      4'd7:    v = 18'd23375;
      4'd8:    v = 18'd14624;
      4'd9:    v = 18'd6905;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage

[src/graph_coloring_annealer_core.sv]
// top level: register port, sequencer and datapath of the graph colouring annealer
//
// requests enter on in_valid/in_stall and each gives one result on out_valid/out_stall.
// a request is taken when valid is high and stall low; one request is worked on at a time.
// the conflict recount reads one node pair a cycle from the dual-read arc and colour
// memories and dominates the step time; node and colour choice share a single
// remainder unit.
// the result sits in an output register: while the receiver stalls it holds, and the
// block still takes and works on the next request, which then waits for the register.
// reset clears the arc and colour valid bits at once (no clearing pass), the anneal
// state and the configuration registers to their defaults.
// configuration writes go through the register port at byte address 4*index; the
// user must make them while no request is in flight, the block does not enforce it.
module graph_coloring_annealer_core #(
  parameter int NODES = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gca_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [5:0]                 node_a,
  input  logic [5:0]                 node_b,
  input  logic                       arc_present,
  input  logic [1:0]                 color,
  input  logic [7:0]                 random_node,
  input  logic [7:0]                 random_color,
  input  logic [3:0]                 random_draw,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [10:0]                cost,
  output logic [10:0]                proposed_cost,
  output logic                       accepted,
  output logic                       finished,
  output logic [7:0]                 step_index
);

  import gca_pkg::*;

  logic [3:0]  node_count;
  logic [2:0]  num_colors;
  logic [15:0] start_temperature;
  logic [7:0]  cooling_factor;
  logic [7:0]  iteration_limit;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count        <= 4'd5;
      num_colors        <= 3'd3;
      start_temperature <= 16'd25600;
      cooling_factor    <= 8'd230;
      iteration_limit   <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NODE_COUNT: node_count        <= pwdata[3:0];
        REG_NUM_COLORS: num_colors        <= pwdata[2:0];
        REG_START_TEMP: start_temperature <= pwdata[15:0];
        REG_COOLING:    cooling_factor    <= pwdata[7:0];
        REG_ITER_LIMIT: iteration_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NODE_COUNT: prdata = 32'(node_count);
      REG_NUM_COLORS: prdata = 32'(num_colors);
      REG_START_TEMP: prdata = 32'(start_temperature);
      REG_COOLING:    prdata = 32'(cooling_factor);
      REG_ITER_LIMIT: prdata = 32'(iteration_limit);
      default:        prdata = '0;
    endcase
  end

  gca_cmd_t    cmd;
  gca_status_t status;

  gca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gca_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .node_count        (node_count),
    .num_colors        (num_colors),
    .start_temperature (start_temperature),
    .cooling_factor    (cooling_factor),
    .iteration_limit   (iteration_limit),
    .action            (action),
    .node_a            (node_a),
    .node_b            (node_b),
    .arc_present       (arc_present),
    .color             (color),
    .random_node       (random_node),
    .random_color      (random_color),
    .random_draw       (random_draw),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .cost              (cost),
    .proposed_cost     (proposed_cost),
    .accepted          (accepted),
    .finished          (finished),
    .step_index        (step_index)
  );

endmodule

[src/gca_rem.sv]
// iterative restoring remainder unit, one quotient bit per cycle
module gca_rem (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       busy,
  output logic [7:0] remainder
);

  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [2:0]  k;
  logic [14:0] shifted;

  assign shifted   = 15'(dvs) << k;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == 3'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= divisor;
      k   <= 3'd7;
    end else if (busy) begin
      if (15'(rem) >= shifted) begin
        rem <= rem - shifted[7:0];
      end
      k <= k - 3'd1;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> rem < dvs)
    else $error("remainder not below divisor");

endmodule

[src/gca_datapath.sv]
// arc and colour memories, conflict scan, acceptance arithmetic and result register
module gca_datapath #(
  parameter int NODES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gca_pkg::gca_cmd_t     cmd,
  output gca_pkg::gca_status_t  status,
  input  logic [3:0]            node_count,
  input  logic [2:0]            num_colors,
  input  logic [15:0]           start_temperature,
  input  logic [7:0]            cooling_factor,
  input  logic [7:0]            iteration_limit,
  input  logic [1:0]            action,
  input  logic [5:0]            node_a,
  input  logic [5:0]            node_b,
  input  logic                  arc_present,
  input  logic [1:0]            color,
  input  logic [7:0]            random_node,
  input  logic [7:0]            random_color,
  input  logic [3:0]            random_draw,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [10:0]           cost,
  output logic [10:0]           proposed_cost,
  output logic                  accepted,
  output logic                  finished,
  output logic [7:0]            step_index
);

  import gca_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 2);

  // captured request
  logic [1:0] act;
  logic [5:0] na;
  logic [5:0] nb;
  logic       arc_bit;
  logic [1:0] col_in;
  logic [7:0] rnode;
  logic [7:0] rcol;
  logic [3:0] draw;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act     <= action;
      na      <= node_a;
      nb      <= node_b;
      arc_bit <= arc_present;
      col_in  <= color;
      rnode   <= random_node;
      rcol    <= random_color;
      draw    <= random_draw;
    end
  end

  // clamped sizes
  logic [CW-1:0] n_used;
  logic [2:0]    c_used;

  always_comb begin
    if (node_count == 4'd0) begin
      n_used = CW'(1);
    end else if (32'(node_count) > NODES) begin
      n_used = CW'(NODES);
    end else begin
      n_used = CW'(node_count);
    end
    if (num_colors == 3'd0) begin
      c_used = 3'd1;
    end else if (num_colors > 3'd4) begin
      c_used = 3'd4;
    end else begin
      c_used = num_colors;
    end
  end

  logic na_ok;
  logic nb_ok;
  assign na_ok = 7'(na) < 7'(NODES);
  assign nb_ok = 7'(nb) < 7'(NODES);

  // scan counters
  logic          scan_run;
  logic          scan_more;
  logic [CW-1:0] si;
  logic [CW-1:0] sj;
  logic          p_valid;
  logic [NW-1:0] p_i;
  logic [NW-1:0] p_j;
  logic          trial_on;
  logic [10:0]   total;
  logic          hit;

  // arc memory, one row per source node
  logic [NODES-1:0] arc_mem [NODES];
  logic [NODES-1:0] arc_valid;
  logic [NW-1:0]    arc_addr_a;
  logic [NW-1:0]    arc_addr_b;
  logic [NODES-1:0] rd_row_a;
  logic [NODES-1:0] rd_row_b;
  logic             rd_va;
  logic             rd_vb;
  logic             arc_we;
  logic [NODES-1:0] arc_base;
  logic [NODES-1:0] arc_mask;
  logic [NODES-1:0] arc_wdata;

  assign arc_addr_a = cmd.arc_read ? na[NW-1:0] : si[NW-1:0];
  assign arc_addr_b = sj[NW-1:0];
  assign arc_we     = cmd.arc_write && na_ok && nb_ok;
  assign arc_base   = rd_va ? rd_row_a : '0;
  assign arc_mask   = NODES'(1) << nb[NW-1:0];
  assign arc_wdata  = arc_bit ? (arc_base | arc_mask) : (arc_base & ~arc_mask);

  always_ff @(posedge clk) begin
    rd_row_a <= arc_mem[arc_addr_a];
    rd_row_b <= arc_mem[arc_addr_b];
    rd_va    <= arc_valid[arc_addr_a];
    rd_vb    <= arc_valid[arc_addr_b];
    if (arc_we) begin
      arc_mem[na[NW-1:0]] <= arc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_valid <= '0;
    end else if (arc_we) begin
      arc_valid[na[NW-1:0]] <= 1'b1;
    end
  end

  // colour memory
  logic [1:0]    col_mem [NODES];
  logic [NODES-1:0] col_valid;
  logic [1:0]    rd_ca;
  logic [1:0]    rd_cb;
  logic          rd_vca;
  logic          rd_vcb;
  logic          col_we;
  logic [NW-1:0] col_waddr;
  logic [1:0]    col_wdata;
  logic          keep;
  logic [NW-1:0] tnode;
  logic [1:0]    tcol;

  assign col_we    = (cmd.color_write && na_ok) || (cmd.commit_step && keep);
  assign col_waddr = cmd.commit_step ? tnode : na[NW-1:0];
  assign col_wdata = cmd.commit_step ? tcol : col_in;

  always_ff @(posedge clk) begin
    rd_ca  <= col_mem[si[NW-1:0]];
    rd_cb  <= col_mem[sj[NW-1:0]];
    rd_vca <= col_valid[si[NW-1:0]];
    rd_vcb <= col_valid[sj[NW-1:0]];
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
    end else if (col_we) begin
      col_valid[col_waddr] <= 1'b1;
    end
  end

  // pair walk over i < j < n, one pair a cycle
  assign scan_more = (si + CW'(1)) < n_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      p_valid  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_run <= 1'b1;
      end else if (scan_run && !scan_more) begin
        scan_run <= 1'b0;
      end
      p_valid <= scan_run && scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      si       <= '0;
      sj       <= CW'(1);
      total    <= '0;
      trial_on <= cmd.use_trial;
    end else begin
      if (scan_run && scan_more) begin
        p_i <= si[NW-1:0];
        p_j <= sj[NW-1:0];
        if ((sj + CW'(1)) < n_used) begin
          sj <= sj + CW'(1);
        end else begin
          si <= si + CW'(1);
          sj <= si + CW'(2);
        end
      end
      if (p_valid && hit) begin
        total <= total + 11'd1;
      end
    end
  end

  logic [1:0] ci;
  logic [1:0] cj;

  always_comb begin
    ci = rd_vca ? rd_ca : 2'd0;
    cj = rd_vcb ? rd_cb : 2'd0;
    if (trial_on && p_i == tnode) begin
      ci = tcol;
    end
    if (trial_on && p_j == tnode) begin
      cj = tcol;
    end
    hit = rd_va && rd_row_a[p_j] && rd_vb && rd_row_b[p_i] && (ci == cj);
  end

  // random node and colour selection
  logic       rem_busy;
  logic [7:0] rem_q;

  gca_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.rem_start),
    .dividend  (cmd.rem_color ? rcol : rnode),
    .divisor   (cmd.rem_color ? {5'd0, c_used} : 8'(n_used)),
    .busy      (rem_busy),
    .remainder (rem_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_node) begin
      tnode <= rem_q[NW-1:0];
    end
    if (cmd.take_color) begin
      tcol <= rem_q[1:0];
    end
  end

  // anneal state
  logic [10:0] cur_cost;
  logic [15:0] temperature;
  logic [7:0]  step_cnt;
  logic        done;
  logic [33:0] prod_rhs;
  logic [23:0] prod_cool;
  logic [10:0] diff;
  logic [34:0] lhs;
  logic [10:0] cost_next;
  logic [7:0]  step_next;
  logic [10:0] res_prop;
  logic        res_acc;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_rhs  <= 34'(temperature) * 34'(ln_q16(draw));
      prod_cool <= 24'(temperature) * 24'(cooling_factor);
    end
  end

  assign diff      = total - cur_cost;
  assign lhs       = {diff, 24'd0};
  assign keep      = (total == 11'd0) || (total <= cur_cost) || (draw == 4'd0) ||
                     ((draw <= DRAW_MAX) && (lhs <= 35'(prod_rhs)));
  assign cost_next = keep ? total : cur_cost;
  assign step_next = (step_cnt == 8'hFF) ? step_cnt : step_cnt + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_cost    <= '0;
      temperature <= '0;
      step_cnt    <= '0;
      done        <= 1'b0;
    end else if (cmd.commit_start) begin
      cur_cost    <= total;
      temperature <= start_temperature;
      step_cnt    <= '0;
      done        <= (total == 11'd0);
    end else if (cmd.commit_step) begin
      cur_cost    <= cost_next;
      temperature <= prod_cool[23:8];
      step_cnt    <= step_next;
      done        <= (cost_next == 11'd0) || (step_next >= iteration_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_prop <= '0;
      res_acc  <= 1'b0;
    end else if (cmd.commit_step) begin
      res_prop <= total;
      res_acc  <= keep;
    end
  end

  // result register
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cost          <= cur_cost;
      proposed_cost <= res_prop;
      accepted      <= res_acc;
      finished      <= done;
      step_index    <= step_cnt;
    end
  end

  assign status.act       = act;
  assign status.done      = done;
  assign status.rem_busy  = rem_busy;
  assign status.scan_busy = scan_run || p_valid;
  assign status.out_free  = out_free;

  a_pair_ordered: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> p_i < p_j)
    else $error("scan pair out of order");

  a_no_step_when_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_step |-> !done)
    else $error("anneal step committed after finish");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result overwritten while held");

endmodule

[src/gca_ctrl.sv]
// sequencer that steps the datapath through each request
module gca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gca_pkg::gca_status_t  status,
  output gca_pkg::gca_cmd_t     cmd
);

  import gca_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_ARC_RD    = 4'd2;
  localparam logic [3:0] S_ARC_WR    = 4'd3;
  localparam logic [3:0] S_REM_NODE  = 4'd4;
  localparam logic [3:0] S_REM_COLOR = 4'd5;
  localparam logic [3:0] S_SCAN      = 4'd6;
  localparam logic [3:0] S_MULT      = 4'd7;
  localparam logic [3:0] S_COMMIT    = 4'd8;
  localparam logic [3:0] S_START_FIN = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.act)
          ACT_SET_ARC: begin
            state_next = S_ARC_RD;
          end
          ACT_SET_COLOR: begin
            cmd.color_write = 1'b1;
            state_next      = S_OUT;
          end
          ACT_START: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          ACT_STEP: begin
            if (status.done) begin
              state_next = S_OUT;
            end else begin
              cmd.rem_start = 1'b1;
              state_next    = S_REM_NODE;
            end
          end
        endcase
      end
      S_ARC_RD: begin
        cmd.arc_read = 1'b1;
        state_next   = S_ARC_WR;
      end
      S_ARC_WR: begin
        cmd.arc_write = 1'b1;
        state_next    = S_OUT;
      end
      S_REM_NODE: begin
        if (!status.rem_busy) begin
          cmd.take_node = 1'b1;
          cmd.rem_start = 1'b1;
          cmd.rem_color = 1'b1;
          state_next    = S_REM_COLOR;
        end
      end
      S_REM_COLOR: begin
        if (!status.rem_busy) begin
          cmd.take_color = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.use_trial  = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!status.scan_busy) begin
          state_next = (status.act == ACT_START) ? S_START_FIN : S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        state_next      = S_OUT;
      end
      S_START_FIN: begin
        cmd.commit_start = 1'b1;
        state_next       = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
